// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks in this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, masked while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/lpd2d_pkg.sv =====
// ----------------------------------------------------------------------------
// 2-D local peak detector package
// Sizes, register indexes, result kinds and the per-pixel result bundle.
// ----------------------------------------------------------------------------
package lpd2d_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int VALUE_BITS = 16;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int TOTAL_W = 23;

  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;

  // Result bundle queue between the compare stage and the output register.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Result kinds.
  localparam logic KIND_PEAK    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Bit positions in a bundle's result mask, in output order.
  localparam int RES_UP      = 0;
  localparam int RES_LEFT    = 1;
  localparam int RES_SELF    = 2;
  localparam int RES_SUMMARY = 3;
  localparam int RES_N       = 4;

  // All results caused by one pixel.
  typedef struct packed {
    logic [RES_N-1:0]   mask;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [TOTAL_W-1:0] base;
  } bundle_t;

endpackage

// ===== src/local_peak_detector_2d_top.sv =====
// ----------------------------------------------------------------------------
// 2-D local peak detector
// Streams a raster-order matrix and reports every element that is no smaller
// than each of its up, down, left and right neighbors, then a frame summary.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel takes one signed sample per transfer in raster order.
//   The out_ channel gives peak reports (row, column, running total) and,
//   after the last sample of a frame, a summary with the frame total.
//   out_last_of_run marks the last result caused by one sample.
//   Frame size comes from cfg_ writes, which also restart the frame; write
//   only while the block is idle.
// Timing:
//   A sample is taken on the cycle it arrives: one per clock while in_ready
//   is high. The line memories are read at the input transfer, compared and
//   written back in the following cycle; results then pass through the
//   result queue to the output register. The single output port moves one
//   result per clock while out_ready is high. In the last row a sample can
//   cause two results (four on the final sample), so there the input slows
//   once the four-entry result queue has filled.
// Reset and stalls:
//   Reset empties the pipeline and queue and restores the full frame size;
//   the line memories need no clearing. When the receiver stalls, results
//   collect in the queue and in_ready drops once it may overflow.
// ----------------------------------------------------------------------------
module local_peak_detector_2d_top
  import lpd2d_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  // Configuration
  input  logic                         cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wr_data,
  // Sample input
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] in_pixel_value,
  // Results
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_result_kind,
  output logic [ROW_W-1:0]             out_peak_row,
  output logic [COL_W-1:0]             out_peak_col,
  output logic [TOTAL_W-1:0]           out_peak_total,
  output logic                         out_last_of_run
);

  // Frame geometry, stored as last column and last row.
  logic [COL_W-1:0]        col_last_r;
  logic [ROW_W-1:0]        row_last_r;
  logic [WIDTH_REG_W-1:0]  cfg_w;
  logic [HEIGHT_REG_W-1:0] cfg_h;
  logic [WIDTH_REG_W-1:0]  eff_w;
  logic [HEIGHT_REG_W-1:0] eff_h;
  logic                    cfg_restart;

  // Raster position of the next sample.
  logic [COL_W-1:0] col_count_r;
  logic [ROW_W-1:0] row_count_r;
  logic             in_xfer;

  // Line memories.
  logic signed [VALUE_BITS-1:0] row_mem [MAX_WIDTH];
  logic                         flag_mem [MAX_WIDTH];
  logic signed [VALUE_BITS-1:0] up_rd_r;
  logic                         flag_rd_r;
  logic                         flag_we;
  logic [COL_W-1:0]             flag_waddr;
  logic                         flag_wdata;

  // Compare stage.
  logic                         s1_valid_r;
  logic signed [VALUE_BITS-1:0] s1_pix_r;
  logic [ROW_W-1:0]             s1_row_r;
  logic [COL_W-1:0]             s1_col_r;
  logic                         s1_top_r;
  logic                         s1_left_r;
  logic                         s1_last_row_r;
  logic                         s1_last_col_r;

  logic signed [VALUE_BITS-1:0] prev_sample_r;
  logic                         prev_fail_r;
  logic                         last_col_fail_r;
  logic [TOTAL_W-1:0]           peak_count_r;
  logic [TOTAL_W-1:0]           peak_count_nxt;

  logic          up_fail;
  logic          fail_now;
  logic          hit_up;
  logic          hit_left;
  logic          hit_self;
  logic          is_summary;
  logic [1:0]    hit_cnt;
  bundle_t       s1_bundle;
  logic          push;

  // Result queue.
  bundle_t               fifo_mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] fifo_cnt_r;
  logic                  pop;

  // Output stage.
  bundle_t            head;
  logic [RES_N-1:0]   done_r;
  logic [RES_N-1:0]   pending;
  logic [RES_N-1:0]   sel;
  logic               load;
  logic               sel_last;
  logic               sel_kind;
  logic [ROW_W-1:0]   sel_row;
  logic [COL_W-1:0]   sel_col;
  logic [1:0]         sel_add;
  logic [TOTAL_W-1:0] sel_total;

  logic               out_valid_r;
  logic               out_kind_r;
  logic [ROW_W-1:0]   out_row_r;
  logic [COL_W-1:0]   out_col_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic               out_last_r;

  // Clamp written sizes to the supported range.
  always_comb begin
    cfg_w = cfg_wr_data[WIDTH_REG_W-1:0];
    cfg_h = cfg_wr_data[HEIGHT_REG_W-1:0];
    eff_w = cfg_w;
    eff_h = cfg_h;
    if (cfg_w < WIDTH_REG_W'(2)) begin
      eff_w = WIDTH_REG_W'(2);
    end else if (cfg_w > WIDTH_REG_W'(MAX_WIDTH)) begin
      eff_w = WIDTH_REG_W'(MAX_WIDTH);
    end
    if (cfg_h < HEIGHT_REG_W'(2)) begin
      eff_h = HEIGHT_REG_W'(2);
    end else if (cfg_h > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      eff_h = HEIGHT_REG_W'(MAX_HEIGHT);
    end
  end

  // Configuration registers; every write restarts the frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_last_r <= COL_W'(MAX_WIDTH - 1);
      row_last_r <= ROW_W'(MAX_HEIGHT - 1);
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  col_last_r <= COL_W'(eff_w - WIDTH_REG_W'(1));
        REG_FRAME_HEIGHT: row_last_r <= ROW_W'(eff_h - HEIGHT_REG_W'(1));
        default:          ;
      endcase
    end
  end

  assign cfg_restart = cfg_wr_en;

  // Accept while the queue has room for everything already in flight.
  assign in_ready = (fifo_cnt_r + FIFO_CNT_W'(s1_valid_r)) < FIFO_CNT_W'(FIFO_DEPTH);
  assign in_xfer  = in_valid && in_ready;

  // Raster counters advance at each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_restart) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else if (in_xfer) begin
      if (col_count_r == col_last_r) begin
        col_count_r <= '0;
        if (row_count_r == row_last_r) begin
          row_count_r <= '0;
        end else begin
          row_count_r <= row_count_r + ROW_W'(1);
        end
      end else begin
        col_count_r <= col_count_r + COL_W'(1);
      end
    end
  end

  // Sample line: read the upper neighbor, write back the current sample.
  always_ff @(posedge clk) begin
    up_rd_r <= row_mem[col_count_r];
    if (s1_valid_r) begin
      row_mem[s1_col_r] <= s1_pix_r;
    end
  end

  // Fail flag line: a column's flag is final once its right neighbor is
  // seen, so it is written one column late. Forward it when a two-column
  // frame reads the same column in the same cycle.
  assign flag_we    = s1_valid_r && !s1_left_r;
  assign flag_waddr = s1_col_r - COL_W'(1);
  assign flag_wdata = prev_fail_r || (prev_sample_r < s1_pix_r);

  always_ff @(posedge clk) begin
    if (flag_we && (flag_waddr == col_count_r)) begin
      flag_rd_r <= flag_wdata;
    end else begin
      flag_rd_r <= flag_mem[col_count_r];
    end
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
  end

  // Compare stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_xfer;
    end
    s1_pix_r      <= in_pixel_value;
    s1_row_r      <= row_count_r;
    s1_col_r      <= col_count_r;
    s1_top_r      <= (row_count_r == '0);
    s1_left_r     <= (col_count_r == '0);
    s1_last_row_r <= (row_count_r == row_last_r);
    s1_last_col_r <= (col_count_r == col_last_r);
  end

  // Verdicts for the pixel above, the pixel to the left and the pixel itself.
  always_comb begin
    up_fail    = s1_last_col_r ? last_col_fail_r : flag_rd_r;
    hit_up     = !s1_top_r && !(up_fail || (up_rd_r < s1_pix_r));
    fail_now   = (!s1_top_r && (s1_pix_r < up_rd_r)) ||
                 (!s1_left_r && (s1_pix_r < prev_sample_r));
    hit_left   = s1_last_row_r && !s1_left_r && !flag_wdata;
    is_summary = s1_last_row_r && s1_last_col_r;
    hit_self   = is_summary && !fail_now;
    hit_cnt    = 2'(hit_up) + 2'(hit_left) + 2'(hit_self);

    if (is_summary) begin
      peak_count_nxt = '0;
    end else begin
      peak_count_nxt = peak_count_r + TOTAL_W'(hit_cnt);
    end

    s1_bundle.mask[RES_UP]      = hit_up;
    s1_bundle.mask[RES_LEFT]    = hit_left;
    s1_bundle.mask[RES_SELF]    = hit_self;
    s1_bundle.mask[RES_SUMMARY] = is_summary;
    s1_bundle.row               = s1_row_r;
    s1_bundle.col               = s1_col_r;
    s1_bundle.base              = peak_count_r;
    push = s1_valid_r && (s1_bundle.mask != '0);
  end

  // Running state carried from one pixel to the next.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sample_r   <= '0;
      prev_fail_r     <= 1'b0;
      last_col_fail_r <= 1'b0;
      peak_count_r    <= '0;
    end else if (cfg_restart) begin
      peak_count_r <= '0;
    end else if (s1_valid_r) begin
      prev_sample_r <= s1_pix_r;
      prev_fail_r   <= fail_now;
      peak_count_r  <= peak_count_nxt;
      if (s1_last_col_r) begin
        last_col_fail_r <= fail_now;
      end
    end
  end

  // Result bundle queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
    if (push) begin
      fifo_mem_r[wr_ptr_r] <= s1_bundle;
    end
  end

  // Pick the next pending result of the head bundle in output order.
  always_comb begin
    head    = fifo_mem_r[rd_ptr_r];
    pending = head.mask & ~done_r;
    load    = (fifo_cnt_r != '0) && (!out_valid_r || out_ready);

    sel = '0;
    if (pending[RES_UP]) begin
      sel[RES_UP] = 1'b1;
    end else if (pending[RES_LEFT]) begin
      sel[RES_LEFT] = 1'b1;
    end else if (pending[RES_SELF]) begin
      sel[RES_SELF] = 1'b1;
    end else begin
      sel[RES_SUMMARY] = 1'b1;
    end
    sel_last = ((pending & ~sel) == '0);

    sel_kind = KIND_PEAK;
    sel_row  = head.row;
    sel_col  = head.col;
    sel_add  = 2'd1;
    if (sel[RES_UP]) begin
      sel_row = head.row - ROW_W'(1);
    end else if (sel[RES_LEFT]) begin
      sel_col = head.col - COL_W'(1);
      sel_add = 2'(head.mask[RES_UP]) + 2'd1;
    end else if (sel[RES_SELF]) begin
      sel_add = 2'(head.mask[RES_UP]) + 2'(head.mask[RES_LEFT]) + 2'd1;
    end else begin
      sel_kind = KIND_SUMMARY;
      sel_row  = '0;
      sel_col  = '0;
      sel_add  = 2'(head.mask[RES_UP]) + 2'(head.mask[RES_LEFT]) +
                 2'(head.mask[RES_SELF]);
    end
    sel_total = head.base + TOTAL_W'(sel_add);
    pop       = load && sel_last;
  end

  // Output register and progress through the head bundle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      done_r      <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        done_r      <= sel_last ? '0 : (done_r | sel);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (load) begin
      out_kind_r  <= sel_kind;
      out_row_r   <= sel_row;
      out_col_r   <= sel_col;
      out_total_r <= sel_total;
      out_last_r  <= sel_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_peak_row    = out_row_r;
  assign out_peak_col    = out_col_r;
  assign out_peak_total  = out_total_r;
  assign out_last_of_run = out_last_r;

endmodule

// ===== src/lpd2d_checker.sv =====
// ----------------------------------------------------------------------------
// 2-D local peak detector port checker
// Watches the top level's ports and flags illegal result sequences.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpd2d_checker
  import lpd2d_pkg::*;
(
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_result_kind,
  input logic [ROW_W-1:0]             out_peak_row,
  input logic [COL_W-1:0]             out_peak_col,
  input logic [TOTAL_W-1:0]           out_peak_total,
  input logic                         out_last_of_run
);

  // Nothing is offered on the output in the cycle after a reset edge.
  `ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "output valid after reset")

  // A stalled result holds its payload.
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_result_kind) && $stable(out_peak_row) && $stable(out_peak_col) && $stable(out_peak_total) && $stable(out_last_of_run), "stalled result changed")

  // A summary carries no coordinates and closes the run of its sample.
  `ASSERT_CLK(a_summary_form, clk, rst_n, out_valid && (out_result_kind == KIND_SUMMARY) |-> (out_peak_row == '0) && (out_peak_col == '0) && out_last_of_run, "malformed summary")

  // A peak report always counts at least itself.
  `ASSERT_CLK(a_peak_total, clk, rst_n, out_valid && (out_result_kind == KIND_PEAK) |-> (out_peak_total != '0), "peak report with zero total")

endmodule

bind local_peak_detector_2d_top lpd2d_checker u_lpd2d_checker (.*);

// ===== verif/local_peak_detector_2d_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// 2-D local peak detector testbench
// Streams raster-order frames of signed samples through the detector with
// random idle cycles on the sample and result channels. A shadow copy of the
// line buffer, the pending-fail flags and the counters predicts every peak
// report and frame summary, and each result transfer is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module local_peak_detector_2d_top_test
  import lpd2d_pkg::*;
();

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int RANDOM_PIXELS = 130;
  localparam int MAX_WAIT      = 12;

  typedef logic signed [VALUE_BITS-1:0] pix_t;

  localparam pix_t PIX_MAX = 16'sh7FFF;
  localparam pix_t PIX_MIN = 16'sh8000;

  // How random sample values are drawn.
  typedef enum int {
    VAL_TIES,
    VAL_FULL,
    VAL_EXTREME
  } pix_mode_t;

  // One predicted result.
  typedef struct {
    logic               kind;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } report_t;

  // Block ports.
  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  cfg_wr_en      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data    = '0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  pix_t                  in_pixel_value = '0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic                  out_result_kind;
  logic [ROW_W-1:0]      out_peak_row;
  logic [COL_W-1:0]      out_peak_col;
  logic [TOTAL_W-1:0]    out_peak_total;
  logic                  out_last_of_run;

  // Shadow state of the detector.
  pix_t                    above_row [MAX_WIDTH];
  bit                      lost_cmp  [MAX_WIDTH];
  pix_t                    left_pix;
  int unsigned             scan_row;
  int unsigned             scan_col;
  logic [TOTAL_W-1:0]      peak_tally;
  logic [WIDTH_REG_W-1:0]  width_setting;
  logic [HEIGHT_REG_W-1:0] height_setting;
  report_t                 reports_due[$];

  // Idle control and bookkeeping.
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  int unsigned ready_hold;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned pixels_sent;
  int unsigned peaks_seen;
  int unsigned frames_seen;

  local_peak_detector_2d_top i_dut (.*);

  always #(CLK_HALF) clk = ~clk;

  // Effective frame size after clamping.
  function automatic int unsigned frame_cols();
    if (width_setting < 2) return 2;
    if (width_setting > MAX_WIDTH) return MAX_WIDTH;
    return width_setting;
  endfunction

  function automatic int unsigned frame_rows();
    if (height_setting < 2) return 2;
    if (height_setting > MAX_HEIGHT) return MAX_HEIGHT;
    return height_setting;
  endfunction

  function automatic void restart_scan();
    scan_row   = 0;
    scan_col   = 0;
    peak_tally = '0;
  endfunction

  function automatic void queue_report(logic kind, int unsigned r, int unsigned c);
    report_t rep;
    rep.kind  = kind;
    rep.row   = r[ROW_W-1:0];
    rep.col   = c[COL_W-1:0];
    rep.total = peak_tally;
    rep.last  = 1'b0;
    reports_due.push_back(rep);
  endfunction

  // Works out the results caused by one accepted sample.
  function automatic void judge_pixel(pix_t v);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int unsigned n;
    bit          lost;
    w    = frame_cols();
    h    = frame_rows();
    r    = scan_row;
    c    = scan_col;
    n    = 0;
    lost = 1'b0;
    // The sample below settles the verdict of the element above it.
    if (r > 0) begin
      if (!lost_cmp[c] && !(above_row[c] < v)) begin
        peak_tally = peak_tally + TOTAL_W'(1);
        queue_report(KIND_PEAK, r - 1, c);
        n++;
      end
      lost = v < above_row[c];
    end
    // Compare with the left neighbor, both ways.
    if (c > 0) begin
      if (v < left_pix) lost = 1'b1;
      if (left_pix < v) lost_cmp[c-1] = 1'b1;
    end
    lost_cmp[c]  = lost;
    above_row[c] = v;
    // In the last row the left neighbor is final once this sample is in.
    if (r == h - 1) begin
      if (c > 0 && !lost_cmp[c-1]) begin
        peak_tally = peak_tally + TOTAL_W'(1);
        queue_report(KIND_PEAK, r, c - 1);
        n++;
      end
      if (c == w - 1) begin
        if (!lost_cmp[c]) begin
          peak_tally = peak_tally + TOTAL_W'(1);
          queue_report(KIND_PEAK, r, c);
          n++;
        end
        queue_report(KIND_SUMMARY, 0, 0);
        n++;
      end
    end
    left_pix = v;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) begin
      restart_scan();
    end else begin
      scan_row = r;
      scan_col = c;
    end
    if (n > 0) reports_due[reports_due.size()-1].last = 1'b1;
  endfunction

  function automatic int unsigned draw_wait(bit idle_on);
    return idle_on ? $urandom_range(0, MAX_WAIT) : 0;
  endfunction

  function automatic pix_t draw_pixel(pix_mode_t mode);
    pix_t p;
    case (mode)
      VAL_TIES: begin
        p = pix_t'($urandom_range(0, 3));
        return p - pix_t'(1);
      end
      VAL_FULL: begin
        p = pix_t'($urandom);
        return p;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: return PIX_MIN;
          1: return PIX_MAX;
          2: return '0;
          3: return '1;
          default: begin
            p = pix_t'($urandom);
            return p;
          end
        endcase
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Compares one result transfer with the oldest prediction.
  function automatic void compare_report();
    report_t want;
    if (reports_due.size() == 0) begin
      $error("unexpected result: kind %0d row %0d col %0d total %0d", out_result_kind,
             out_peak_row, out_peak_col, out_peak_total);
      fail_count++;
      return;
    end
    want = reports_due.pop_front();
    check_field("result_kind", want.kind, out_result_kind);
    check_field("peak_row", want.row, out_peak_row);
    check_field("peak_col", want.col, out_peak_col);
    check_field("peak_total", want.total, out_peak_total);
    check_field("last_of_run", want.last, out_last_of_run);
    if (want.kind == KIND_SUMMARY) frames_seen++;
    else peaks_seen++;
  endfunction

  // Result side: checks each transfer, then holds ready low for a random wait.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        compare_report();
        ready_hold = draw_wait(recv_idle);
      end else if (ready_hold > 0) begin
        ready_hold--;
      end
      out_ready <= (ready_hold == 0);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("local_peak_detector_2d_top_test NOT OK");
      $finish;
    end
  end

  // Sends one sample; valid is only lowered when a wait comes first.
  task automatic send_pixel(pix_t v);
    int unsigned gap;
    gap = draw_wait(send_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    judge_pixel(v);
    pixels_sent++;
  endtask

  task automatic send_pixels(int unsigned count, pix_mode_t mode);
    repeat (count) send_pixel(draw_pixel(mode));
  endtask

  // Waits for all results, then for samples that cause none to leave the pipe.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; the block restarts its frame on any write.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == REG_FRAME_WIDTH) width_setting = data[WIDTH_REG_W-1:0];
    else height_setting = data;
    restart_scan();
  endtask

  task automatic set_frame(logic [CFG_DATA_W-1:0] cols, logic [CFG_DATA_W-1:0] rows);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, cols);
    write_reg(REG_FRAME_HEIGHT, rows);
  endtask

  // The reset size is the largest frame; its first row reports nothing.
  task automatic test_reset_size();
    send_pixel(PIX_MAX);
    send_pixel(PIX_MIN);
  endtask

  // Sizes below two clamp to a 2x2 frame; extreme values in the corners.
  task automatic test_corner_extremes();
    set_frame(0, 1);
    send_pixel(PIX_MAX);
    send_pixel(PIX_MIN);
    send_pixel(PIX_MIN);
    send_pixel(PIX_MAX);
  endtask

  // Equal neighbors all count as peaks; the final sample causes four results.
  // The previous frame ended, so this one starts without a register write.
  task automatic test_equal_neighbors();
    repeat (4) send_pixel('0);
  endtask

  // 3x3 frame: middle row judged from below, last rows interleave.
  task automatic test_row_interleave();
    pix_t vals [9] = '{5, 5, 1, 2, 5, 5, 5, -1, 5};
    set_frame(3, 3);
    foreach (vals[i]) send_pixel(vals[i]);
  endtask

  // A write in the middle of a frame starts a new one.
  task automatic test_restart_mid_frame();
    send_pixel(7);
    send_pixel(-3);
    wait_idle();
    write_reg(REG_FRAME_HEIGHT, 2);
    send_pixels(6, VAL_TIES);
  endtask

  // The sender stops mid-frame until every pending result is out.
  task automatic test_sender_pause();
    set_frame(4, 4);
    send_pixels(9, VAL_TIES);
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    send_pixels(7, VAL_TIES);
  endtask

  // Random small frames, some cut short by a register write.
  task automatic test_random_frames();
    int unsigned start;
    int unsigned choice;
    int unsigned count;
    bit          must_resize;
    pix_mode_t   mode;
    start       = pixels_sent;
    must_resize = 1'b0;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      send_idle = $urandom_range(0, 3) != 0;
      recv_idle = $urandom_range(0, 3) != 0;
      mode      = pix_mode_t'($urandom_range(0, 2));
      choice    = $urandom_range(0, 9);
      if (must_resize || choice < 7) begin
        wait_idle();
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(choice == 0 ? $urandom_range(0, 1)
                                                            : $urandom_range(2, 7)));
        if (choice != 2) begin
          write_reg(REG_FRAME_HEIGHT,
                    CFG_DATA_W'(choice == 1 ? $urandom_range(0, 1) : $urandom_range(2, 7)));
        end
      end
      count       = frame_cols() * frame_rows();
      must_resize = $urandom_range(0, 7) == 0;
      if (must_resize) count = $urandom_range(1, count - 1);
      send_pixels(count, mode);
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // Height above the maximum clamps; part of a two-column frame.
  task automatic test_tall_frame();
    set_frame(2, {CFG_DATA_W{1'b1}});
    send_pixels(30, VAL_TIES);
  endtask

  // Widest frame, width clamped from an all-ones write; the start of its top row.
  task automatic test_wide_frame();
    set_frame({CFG_DATA_W{1'b1}}, 2);
    repeat (4) begin
      send_idle = $urandom_range(0, 2) != 0;
      recv_idle = $urandom_range(0, 2) != 0;
      send_pixels(MAX_WIDTH / 64, $urandom_range(0, 1) ? VAL_TIES : VAL_EXTREME);
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  initial begin
    // Shadow state after reset.
    foreach (above_row[i]) begin
      above_row[i] = '0;
      lost_cmp[i]  = 1'b0;
    end
    left_pix       = '0;
    width_setting  = MAX_WIDTH;
    height_setting = MAX_HEIGHT;
    restart_scan();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_size();
    test_corner_extremes();
    test_equal_neighbors();
    test_row_interleave();
    test_restart_mid_frame();
    test_sender_pause();
    test_random_frames();
    test_tall_frame();
    test_wide_frame();

    wait_idle();
    $display("Checked %0d peak reports and %0d frame summaries from %0d samples.",
             peaks_seen, frames_seen, pixels_sent);
    $display("Frames from 2x2 to 1024 columns, clamped sizes, restarts and random stalls.");
    if (fail_count == 0) begin
      $display("local_peak_detector_2d_top_test OK");
    end else begin
      $display("local_peak_detector_2d_top_test NOT OK");
    end
    $finish;
  end

endmodule
